// ===== design/bfm_pkg.sv =====
// Shared types and constants for the box filter mipmap chain.
package bfm_pkg;

	localparam int DIM_W = 12;
	localparam int LVL_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam logic [DIM_W-1:0] HEIGHT_LIMIT = 12'd2048;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pix_t;

	// horizontal pair sum, one entry of the line store
	typedef struct packed {
		logic [8:0] r;
		logic [8:0] g;
		logic [8:0] b;
	} psum_t;

	// geometry of the level in work and of the level it feeds
	typedef struct packed {
		logic [DIM_W-1:0] w_cur;
		logic [DIM_W-1:0] h_cur;
		logic [DIM_W-1:0] w_nxt;
		logic [DIM_W-1:0] h_nxt;
	} geo_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MERGE
	} st_t;

endpackage

// ===== design/bfm_line_ram.sv =====
// Single-port line store for the even-row pair sums, registered read.
module bfm_line_ram #(
	parameter int AW = 11,
	parameter int DW = 27
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// one access a cycle, registered read data
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== design/bfm_geom.sv =====
// Level geometry: sizes of the current and next level and the level count.
module bfm_geom #(
	parameter int MAX_LEVELS = 11
) (
	input  logic [bfm_pkg::DIM_W-1:0] width,
	input  logic [bfm_pkg::DIM_W-1:0] height,
	input  logic [bfm_pkg::LVL_W-1:0] lvl,
	output bfm_pkg::geo_t             geo,
	output logic [bfm_pkg::LVL_W-1:0] nlev
);
	import bfm_pkg::*;

	logic [MAX_LEVELS-1:0] lvl_exists;

	// halving by floor repeatedly is a plain shift
	always_comb begin
		geo.w_cur = width >> lvl;
		geo.h_cur = height >> lvl;
		geo.w_nxt = width >> ({1'b0, lvl} + 5'd1);
		geo.h_nxt = height >> ({1'b0, lvl} + 5'd1);
	end

	// level k+1 exists while level k is at least 2 by 2
	always_comb begin
		for (int k = 0; k < MAX_LEVELS; k++) begin
			lvl_exists[k] = ((width >> k) > DIM_W'(1)) && ((height >> k) > DIM_W'(1));
		end
		nlev = LVL_W'($countones(lvl_exists));
	end

endmodule

// ===== design/box_filter_mipmap_chain_unit.sv =====
// Top level of the 2x2 box filter mipmap chain generator.
// Base pixels come in on in_valid/in_ready in raster order, one RGB888 request
// each. Each pixel may finish one pixel in each of several levels; these leave
// on out_valid/out_ready with level, position and colour, level 1 first, with
// last_of_run on the final one of the pixel and frame_done on the last pixel
// of the whole chain. The sizes are set through cfg_write/cfg_index/cfg_data;
// any write restarts the frame.
// A request is taken in the idle state; then each level is a position check
// with a line store access in the evaluation state, and each level finished
// adds a merge with the read data in the merge state. The walk ends at the
// first level that finishes nothing. The single port of the line store sets this.
// Results are held in an output register; a finished result is passed on
// while the next level is checked, and the sequencer waits there if the
// receiver stalls with the output register still full.
// Reset clears the position counters and loads 1024 by 1024; the line store
// and the left pixel store need no clearing, every read follows a write.
module box_filter_mipmap_chain_unit #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_LEVELS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [bfm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfm_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    in_red,
	input  logic [7:0]                    in_green,
	input  logic [7:0]                    in_blue,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [3:0]                    mip_level,
	output logic [9:0]                    x_pos,
	output logic [9:0]                    y_pos,
	output logic [7:0]                    out_red,
	output logic [7:0]                    out_green,
	output logic [7:0]                    out_blue,
	output logic                          last_of_run,
	output logic                          frame_done
);
	import bfm_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CIW = $clog2(MAX_LEVELS + 1);
	localparam int PIW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

	st_t state_q, state_nx;

	logic [DIM_W-1:0] width_q, height_q;
	logic [DIM_W-1:0] cfg_dim;
	logic [DIM_W-1:0] col_q [MAX_LEVELS+1];
	logic [DIM_W-2:0] row_q [MAX_LEVELS+1];
	pix_t pend_q [MAX_LEVELS];

	logic [LVL_W-1:0] lvl_q;
	logic [AW-1:0] base_q;
	pix_t pix_q;
	logic frame_end_q;

	// evaluation results kept for the merge cycle
	psum_t sum_s1;
	logic [DIM_W-2:0] x_s1;
	logic [DIM_W-3:0] y_s1;
	logic done_s1;

	// finished result waiting for its last flag
	logic res_held_q;
	logic [3:0] res_lvl_q;
	logic [9:0] res_x_q, res_y_q;
	pix_t res_pix_q;
	logic res_done_q;

	logic out_valid_q;

	geo_t geo;
	logic [LVL_W-1:0] nlev;
	logic [CIW-1:0] cidx;
	logic [PIW-1:0] pidx;
	logic [DIM_W-1:0] col, col_inc;
	logic [DIM_W-2:0] row;
	logic [DIM_W-1:0] row_inc;
	logic [DIM_W-2:0] x;
	logic [DIM_W-3:0] y;
	logic lvl_ok, in_lvl, pair, emit, wrap_col, wrap_row, push_ok, stall;
	pix_t left;
	psum_t sum, q_rd;
	pix_t avg;
	logic [AW-1:0] idx;
	logic mem_en, mem_we;
	logic [$bits(psum_t)-1:0] mem_rdata;

	bfm_geom #(
		.MAX_LEVELS(MAX_LEVELS)
	) u_geom (
		.width (width_q),
		.height(height_q),
		.lvl   (lvl_q),
		.geo   (geo),
		.nlev  (nlev)
	);

	bfm_line_ram #(
		.AW(AW),
		.DW($bits(psum_t))
	) u_ram (
		.clk  (clk),
		.en   (mem_en),
		.we   (mem_we),
		.addr (idx),
		.wdata(sum),
		.rdata(mem_rdata)
	);

	// position of the level in work and its pairing
	always_comb begin
		cidx = lvl_q[CIW-1:0];
		pidx = lvl_q[PIW-1:0];
		col = col_q[cidx];
		row = row_q[cidx];
		x = col[DIM_W-1:1];
		y = row[DIM_W-2:1];
		lvl_ok = lvl_q < nlev;
		in_lvl = lvl_ok && ({1'b0, x} < geo.w_nxt) && ({2'b0, y} < geo.h_nxt);
		pair = in_lvl && col[0];
		emit = pair && row[0];
		col_inc = col + DIM_W'(1);
		row_inc = {1'b0, row} + DIM_W'(1);
		wrap_col = col_inc >= geo.w_cur;
		wrap_row = row_inc >= geo.h_cur;
		left = pend_q[pidx];
		sum.r = {1'b0, left.r} + {1'b0, pix_q.r};
		sum.g = {1'b0, left.g} + {1'b0, pix_q.g};
		sum.b = {1'b0, left.b} + {1'b0, pix_q.b};
		idx = base_q + AW'(x);
		push_ok = !out_valid_q || out_ready;
		stall = res_held_q && !push_ok;
	end

	// merge of the stored even-row sum with this odd-row sum
	always_comb begin
		logic [9:0] tr, tg, tb;
		q_rd = psum_t'(mem_rdata);
		tr = {1'b0, q_rd.r} + {1'b0, sum_s1.r};
		tg = {1'b0, q_rd.g} + {1'b0, sum_s1.g};
		tb = {1'b0, q_rd.b} + {1'b0, sum_s1.b};
		avg.r = tr[9:2];
		avg.g = tg[9:2];
		avg.b = tb[9:2];
	end

	// configuration value clamp
	always_comb begin
		cfg_dim = (cfg_data == '0) ? DIM_W'(1) : cfg_data;
		if (cfg_index == REG_WIDTH) begin
			if (32'(cfg_dim) > MAX_WIDTH) cfg_dim = DIM_W'(MAX_WIDTH);
		end else begin
			if (cfg_dim > HEIGHT_LIMIT) cfg_dim = HEIGHT_LIMIT;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_EVAL;
			ST_EVAL: if (!stall) state_nx = emit ? ST_MERGE : ST_IDLE;
			ST_MERGE: state_nx = ST_EVAL;
			default: state_nx = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		mem_en = 1'b0;
		mem_we = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EVAL: begin
				mem_en = pair && !stall;
				mem_we = !row[0];
			end
			ST_MERGE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// sizes and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_W'(1024);
			height_q <= DIM_W'(1024);
			frame_end_q <= 1'b0;
			for (int i = 0; i <= MAX_LEVELS; i++) begin
				col_q[i] <= '0;
				row_q[i] <= '0;
			end
		end else if (cfg_write) begin
			if (cfg_index == REG_WIDTH) width_q <= cfg_dim;
			if (cfg_index == REG_HEIGHT) height_q <= cfg_dim;
			for (int i = 0; i <= MAX_LEVELS; i++) begin
				col_q[i] <= '0;
				row_q[i] <= '0;
			end
		end else if (state_q == ST_IDLE) begin
			frame_end_q <= 1'b0;
		end else if (state_q == ST_EVAL && !stall) begin
			if (!emit && (frame_end_q || (lvl_q == '0 && lvl_ok && wrap_col && wrap_row))) begin
				// whole base frame in: restart every level
				for (int i = 0; i <= MAX_LEVELS; i++) begin
					col_q[i] <= '0;
					row_q[i] <= '0;
				end
			end else if (lvl_ok) begin
				if (lvl_q == '0 && wrap_col && wrap_row) frame_end_q <= 1'b1;
				if (wrap_col) begin
					col_q[cidx] <= '0;
					row_q[cidx] <= wrap_row ? '0 : row_inc[DIM_W-2:0];
				end else begin
					col_q[cidx] <= col_inc;
				end
			end
		end
	end

	// sequencer data path
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			pix_q <= '{r: in_red, g: in_green, b: in_blue};
			lvl_q <= '0;
			base_q <= '0;
		end
		if (state_q == ST_EVAL && !stall) begin
			if (in_lvl && !col[0]) pend_q[pidx] <= pix_q;
			sum_s1 <= sum;
			x_s1 <= x;
			y_s1 <= y;
			done_s1 <= ({1'b0, lvl_q} + 5'd1 == {1'b0, nlev})
				&& ({1'b0, x} + DIM_W'(1) == geo.w_nxt)
				&& ({2'b0, y} + DIM_W'(1) == geo.h_nxt);
		end
		if (state_q == ST_MERGE) begin
			pix_q <= avg;
			lvl_q <= lvl_q + LVL_W'(1);
			base_q <= base_q + AW'(geo.w_nxt);
			res_lvl_q <= 4'(lvl_q) + 4'd1;
			res_x_q <= x_s1[9:0];
			res_y_q <= 10'(y_s1);
			res_pix_q <= avg;
			res_done_q <= done_s1;
		end
	end

	// result hold flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_held_q <= 1'b0;
		end else if (state_q == ST_MERGE) begin
			res_held_q <= 1'b1;
		end else if (state_q == ST_EVAL && !stall) begin
			res_held_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EVAL && res_held_q && push_ok) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL && res_held_q && push_ok) begin
			mip_level <= res_lvl_q;
			x_pos <= res_x_q;
			y_pos <= res_y_q;
			out_red <= res_pix_q.r;
			out_green <= res_pix_q.g;
			out_blue <= res_pix_q.b;
			frame_done <= res_done_q;
			// no deeper level finishes: this was the last of the request
			last_of_run <= !emit;
		end
	end

	assign out_valid = out_valid_q;

endmodule
